### sv/reau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reau_pkg
// Shared types and constants of the rational ELU activation unit.
// ----------------------------------------------------------------------------
package reau_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int DEN_W     = DATA_W + 2;
	localparam int QUO_W     = DATA_W;
	localparam int DIV_LAT   = QUO_W + 2;
	localparam int NSTG      = 2 * DIV_LAT + 5;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [DEN_W-1:0]  den_t;

	localparam logic [CFG_IDX_W-1:0] CFG_A_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_A_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_B_HI = 2'd3;

	localparam logic KIND_FWD = 1'b0;
	localparam logic KIND_BWD = 1'b1;

	localparam word_t A_LO_RST = 32'sd6554;
	localparam word_t A_HI_RST = 32'sd655360;
	localparam word_t B_LO_RST = 32'sd6554;
	localparam word_t B_HI_RST = 32'sd655360;

	localparam word_t S32_MAX  = 32'sh7fff_ffff;
	localparam word_t S32_MIN  = 32'sh8000_0000;
	localparam prod_t RND_BIAS = prod_t'((64'sd1 <<< FRAC_BITS) - 64'sd1);

	typedef struct packed {
		logic zero_den;
		logic num_pos;
		logic num_neg;
		logic neg;
		logic ovf;
	} div_flag_t;

	typedef struct packed {
		logic  kind;
		word_t x;
		word_t dy;
	} side_a_t;

	typedef struct packed {
		logic  kind;
		logic  x_neg;
		word_t dy;
		word_t qm;
		word_t qa;
		word_t qb;
		logic  fault;
	} side_b_t;

endpackage
`default_nettype wire

### sv/reau_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reau_if
// Request, result and register write channels of the activation unit.
// ----------------------------------------------------------------------------
interface reau_in_if;
	logic                valid;
	logic                ready;
	logic                kind;
	reau_pkg::word_t     x_value;
	reau_pkg::word_t     param_a;
	reau_pkg::word_t     param_b;
	reau_pkg::word_t     top_value;
	reau_pkg::word_t     top_grad;

	modport source (output valid, kind, x_value, param_a, param_b, top_value, top_grad,
		input ready);
	modport sink (input valid, kind, x_value, param_a, param_b, top_value, top_grad,
		output ready);
endinterface

interface reau_out_if;
	logic                valid;
	logic                ready;
	reau_pkg::word_t     main_result;
	reau_pkg::word_t     grad_a;
	reau_pkg::word_t     grad_b;
	logic                div_fault;

	modport source (output valid, main_result, grad_a, grad_b, div_fault, input ready);
	modport sink (input valid, main_result, grad_a, grad_b, div_fault, output ready);
endinterface

interface reau_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [reau_pkg::CFG_IDX_W-1:0]      index;
	reau_pkg::word_t                     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/reau_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reau_div
// Pipelined signed divider, one quotient bit per stage, saturating to 32 bits.
// ----------------------------------------------------------------------------
module reau_div (
	input  logic            clk,
	input  logic            en,
	input  reau_pkg::prod_t num,
	input  reau_pkg::den_t  den,
	output reau_pkg::word_t quo,
	output logic            fault
);

	logic [reau_pkg::PROD_W-1:0] nmag;
	logic [reau_pkg::DEN_W-1:0]  dabs;
	logic [reau_pkg::DATA_W-1:0] dmag;
	logic [reau_pkg::DATA_W-1:0] hi_w;
	reau_pkg::div_flag_t         flg;

	logic [reau_pkg::DATA_W-1:0] rem_s [0:reau_pkg::QUO_W];
	logic [reau_pkg::QUO_W-1:0]  lq_s  [0:reau_pkg::QUO_W];
	logic [reau_pkg::DATA_W-1:0] d_s   [0:reau_pkg::QUO_W];
	reau_pkg::div_flag_t         f_s   [0:reau_pkg::QUO_W];

	logic [reau_pkg::QUO_W-1:0]  q;
	reau_pkg::div_flag_t         fl;
	reau_pkg::word_t             res;

	always_comb begin
		nmag = num[reau_pkg::PROD_W-1] ? -num : num;
		dabs = den[reau_pkg::DEN_W-1] ? -den : den;
		dmag = dabs[reau_pkg::DATA_W-1:0];
		hi_w = reau_pkg::DATA_W'(nmag[reau_pkg::PROD_W-2:reau_pkg::QUO_W]);
		flg.zero_den = (den == '0);
		flg.num_neg  = num[reau_pkg::PROD_W-1];
		flg.num_pos  = !num[reau_pkg::PROD_W-1] && (num != '0);
		flg.neg      = num[reau_pkg::PROD_W-1] ^ den[reau_pkg::DEN_W-1];
		flg.ovf      = (hi_w >= dmag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi_w;
			lq_s[0]  <= nmag[reau_pkg::QUO_W-1:0];
			d_s[0]   <= dmag;
			f_s[0]   <= flg;
		end
	end

	for (genvar k = 1; k <= reau_pkg::QUO_W; k++) begin : g_step
		logic [reau_pkg::DATA_W:0] r2;
		logic [reau_pkg::DATA_W:0] diff;
		logic                      ge;

		assign r2   = {rem_s[k-1], lq_s[k-1][reau_pkg::QUO_W-1]};
		assign diff = r2 - {1'b0, d_s[k-1]};
		assign ge   = (r2 >= {1'b0, d_s[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[reau_pkg::DATA_W-1:0] : r2[reau_pkg::DATA_W-1:0];
				lq_s[k]  <= {lq_s[k-1][reau_pkg::QUO_W-2:0], ge};
				d_s[k]   <= d_s[k-1];
				f_s[k]   <= f_s[k-1];
			end
		end
	end

	always_comb begin
		q  = lq_s[reau_pkg::QUO_W];
		fl = f_s[reau_pkg::QUO_W];
		if (fl.zero_den) begin
			res = fl.num_pos ? reau_pkg::S32_MAX : (fl.num_neg ? reau_pkg::S32_MIN : '0);
		end else if (!fl.neg) begin
			res = (fl.ovf || q[reau_pkg::QUO_W-1]) ? reau_pkg::S32_MAX : reau_pkg::word_t'(q);
		end else begin
			res = (fl.ovf || (q[reau_pkg::QUO_W-1] && (|q[reau_pkg::QUO_W-2:0])))
				? reau_pkg::S32_MIN : reau_pkg::word_t'(-q);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo   <= res;
			fault <= fl.zero_den;
		end
	end

endmodule
`default_nettype wire

### sv/reau_dx.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reau_dx
// Final input-gradient step: dy times d, scaled down toward zero, saturated.
// ----------------------------------------------------------------------------
module reau_dx (
	input  logic            clk,
	input  logic            en,
	input  reau_pkg::word_t dy,
	input  reau_pkg::word_t d,
	output reau_pkg::word_t dx
);

	reau_pkg::prod_t prod_s1;
	reau_pkg::prod_t adj;
	reau_pkg::prod_t sh;
	reau_pkg::word_t sat;

	always_comb begin
		adj = prod_s1 + (prod_s1[reau_pkg::PROD_W-1] ? reau_pkg::RND_BIAS : '0);
		sh  = adj >>> reau_pkg::FRAC_BITS;
		if (sh > reau_pkg::prod_t'(reau_pkg::S32_MAX)) begin
			sat = reau_pkg::S32_MAX;
		end else if (sh < reau_pkg::prod_t'(reau_pkg::S32_MIN)) begin
			sat = reau_pkg::S32_MIN;
		end else begin
			sat = sh[reau_pkg::DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= dy * d;
			dx      <= sat;
		end
	end

endmodule
`default_nettype wire

### sv/rational_elu_activation_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rational_elu_activation_unit
// Rational ELU forward and backward element unit, Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
//  port   role     contents
//  req    sink     kind, x_value, param_a, param_b, top_value, top_grad
//  rsp    source   main_result, grad_a, grad_b, div_fault
//  cfg    sink     index, data (clamp bounds a_lo, a_hi, b_lo, b_hi)
//
//  One request per cycle while no result is stalled at the output.
//  The pipeline is two chained 34-stage dividers plus clamp, multiply,
//  dx multiply, rounding and output stages.
//  Reset clears valid bits and loads the default bounds; cfg is always ready.
//  A stalled result freezes the whole pipeline; req.ready drops only then.
// ----------------------------------------------------------------------------
module rational_elu_activation_unit (
	input  logic        clk,
	input  logic        arst_n,
	reau_in_if.sink     req,
	reau_out_if.source  rsp,
	reau_cfg_if.sink    cfg
);

	reau_pkg::word_t a_lo_q, a_hi_q, b_lo_q, b_hi_q;
	logic [reau_pkg::NSTG-1:0] vld_q;
	logic adv;

	logic            kind_s1;
	reau_pkg::word_t x_s1, a_s1, b_s1, y_s1, dy_s1;

	logic            kind_s2;
	reau_pkg::word_t x_s2, a_s2, b_s2, dy_s2;
	reau_pkg::prod_t ax_s2, yb_s2, dya_s2, dyy_s2;
	reau_pkg::den_t  bmx_s2;

	logic            x_neg2, x_le0;
	reau_pkg::prod_t m_num, a_num, b_num;
	reau_pkg::den_t  m_den, a_den, b_den;

	reau_pkg::word_t qm, qa, qb, qd, dx;
	logic            fm, fa, fb, fd;

	reau_pkg::side_a_t sa_s [0:reau_pkg::DIV_LAT-1];
	reau_pkg::side_b_t sb_s [0:reau_pkg::DIV_LAT-1];
	reau_pkg::side_b_t sc_s [0:1];
	reau_pkg::side_b_t sb_in, sc_in;

	reau_pkg::prod_t d_num;
	reau_pkg::den_t  d_den;

	reau_pkg::word_t main_q, ga_q, gb_q;
	logic            fault_q;

	function automatic reau_pkg::word_t clampw(reau_pkg::word_t v, reau_pkg::word_t lo,
		reau_pkg::word_t hi);
		reau_pkg::word_t r;
		r = v;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r;
	endfunction

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_lo_q <= reau_pkg::A_LO_RST;
			a_hi_q <= reau_pkg::A_HI_RST;
			b_lo_q <= reau_pkg::B_LO_RST;
			b_hi_q <= reau_pkg::B_HI_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				reau_pkg::CFG_A_LO: a_lo_q <= cfg.data;
				reau_pkg::CFG_A_HI: a_hi_q <= cfg.data;
				reau_pkg::CFG_B_LO: b_lo_q <= cfg.data;
				reau_pkg::CFG_B_HI: b_hi_q <= cfg.data;
			endcase
		end
	end

	// pipeline control
	assign adv       = !vld_q[reau_pkg::NSTG-1] || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[reau_pkg::NSTG-2:0], req.valid};
		end
	end

	// clamp
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= req.kind;
			x_s1    <= req.x_value;
			a_s1    <= clampw(req.param_a, a_lo_q, a_hi_q);
			b_s1    <= clampw(req.param_b, b_lo_q, b_hi_q);
			y_s1    <= req.top_value;
			dy_s1   <= req.top_grad;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			x_s2    <= x_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			dy_s2   <= dy_s1;
			ax_s2   <= a_s1 * x_s1;
			yb_s2   <= y_s1 * b_s1;
			dya_s2  <= dy_s1 * a_s1;
			dyy_s2  <= dy_s1 * y_s1;
			bmx_s2  <= reau_pkg::den_t'(b_s1) - reau_pkg::den_t'(x_s1);
		end
	end

	// divider operand select
	always_comb begin
		x_neg2 = x_s2[reau_pkg::DATA_W-1];
		x_le0  = x_neg2 || (x_s2 == '0);
		if (kind_s2 == reau_pkg::KIND_FWD) begin
			m_num = ax_s2;
			m_den = x_le0 ? bmx_s2 : reau_pkg::den_t'(b_s2);
		end else if (x_neg2) begin
			m_num = yb_s2;
			m_den = bmx_s2;
		end else begin
			m_num = dya_s2;
			m_den = reau_pkg::den_t'(b_s2);
		end
		a_num = dyy_s2;
		a_den = reau_pkg::den_t'(a_s2);
		b_num = -dyy_s2;
		b_den = x_le0 ? bmx_s2 : reau_pkg::den_t'(b_s2);
	end

	reau_div u_div_m (.clk(clk), .en(adv), .num(m_num), .den(m_den), .quo(qm), .fault(fm));
	reau_div u_div_a (.clk(clk), .en(adv), .num(a_num), .den(a_den), .quo(qa), .fault(fa));
	reau_div u_div_b (.clk(clk), .en(adv), .num(b_num), .den(b_den), .quo(qb), .fault(fb));

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s[0] <= '{kind: kind_s2, x: x_s2, dy: dy_s2};
			for (int k = 1; k < reau_pkg::DIV_LAT; k++) sa_s[k] <= sa_s[k-1];
		end
	end

	// second division for dx on negative x
	always_comb begin
		sb_in.kind  = sa_s[reau_pkg::DIV_LAT-1].kind;
		sb_in.x_neg = sa_s[reau_pkg::DIV_LAT-1].x[reau_pkg::DATA_W-1];
		sb_in.dy    = sa_s[reau_pkg::DIV_LAT-1].dy;
		sb_in.qm    = qm;
		sb_in.qa    = sb_in.kind ? qa : '0;
		sb_in.qb    = sb_in.kind ? qb : '0;
		sb_in.fault = fm || (sb_in.kind && (fa || fb));
		d_num = reau_pkg::prod_t'(qm) <<< reau_pkg::FRAC_BITS;
		d_den = reau_pkg::den_t'(sa_s[reau_pkg::DIV_LAT-1].x);
	end

	reau_div u_div_d (.clk(clk), .en(adv), .num(d_num), .den(d_den), .quo(qd), .fault(fd));

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s[0] <= sb_in;
			for (int k = 1; k < reau_pkg::DIV_LAT; k++) sb_s[k] <= sb_s[k-1];
		end
	end

	always_comb begin
		sc_in       = sb_s[reau_pkg::DIV_LAT-1];
		sc_in.fault = sb_s[reau_pkg::DIV_LAT-1].fault ||
			(sb_s[reau_pkg::DIV_LAT-1].kind && sb_s[reau_pkg::DIV_LAT-1].x_neg && fd);
	end

	reau_dx u_dx (.clk(clk), .en(adv), .dy(sb_s[reau_pkg::DIV_LAT-1].dy), .d(qd), .dx(dx));

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s[0] <= sc_in;
			sc_s[1] <= sc_s[0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			main_q  <= (sc_s[1].kind && sc_s[1].x_neg) ? dx : sc_s[1].qm;
			ga_q    <= sc_s[1].qa;
			gb_q    <= sc_s[1].qb;
			fault_q <= sc_s[1].fault;
		end
	end

	assign rsp.valid       = vld_q[reau_pkg::NSTG-1];
	assign rsp.main_result = main_q;
	assign rsp.grad_a      = ga_q;
	assign rsp.grad_b      = gb_q;
	assign rsp.div_fault   = fault_q;

endmodule
`default_nettype wire

### sv/reau_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reau_chk
// Port-level checks of the activation unit, bound to the top level.
// ----------------------------------------------------------------------------
module reau_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input logic            cfg_ready,
	input reau_pkg::word_t rsp_main,
	input reau_pkg::word_t rsp_ga,
	input reau_pkg::word_t rsp_gb,
	input logic            rsp_fault
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_main, rsp_ga, rsp_gb, rsp_fault}))
		else $error("result changed while stalled");

	// request side only stalls behind a waiting result
	a_req_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> (req_ready == (!rsp_valid || rsp_ready)))
		else $error("request stall without waiting result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register port not ready");

endmodule

bind rational_elu_activation_unit reau_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.cfg_ready (cfg.ready),
	.rsp_main  (rsp.main_result),
	.rsp_ga    (rsp.grad_a),
	.rsp_gb    (rsp.grad_b),
	.rsp_fault (rsp.div_fault)
);
`default_nettype wire
